[hdl/gjls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjls_pkg
// Shared widths and types for the gang job list scheduler.
// ----------------------------------------------------------------------------
package gjls_pkg;
    localparam int MaxProcs = 64;
    localparam int IdxBits = $clog2(MaxProcs);
    localparam int CntBits = IdxBits + 1;
    localparam int TimeBits = 32;

    // the table entry: processor id and its finish time
    typedef struct packed {
        logic [IdxBits-1:0]  id;
        logic [TimeBits-1:0] fin;
    } entry_t;

    localparam int EntryBits = $bits(entry_t);

    typedef struct packed {
        logic [TimeBits-1:0] arrive_time;
        logic [TimeBits-1:0] run_time;
        logic [6:0]          gang_size;
    } job_t;

    typedef struct packed {
        logic [5:0]          cpu_id;
        logic [TimeBits-1:0] start_time;
        logic [TimeBits-1:0] done_time;
        logic                last;
        logic                error;
    } result_t;
endpackage
`default_nettype wire

[hdl/gjls_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjls_job_if / gjls_res_if / gjls_cfg_if
// Valid/ready channels for jobs, results and configuration writes.
// ----------------------------------------------------------------------------
interface gjls_job_if;
    logic valid;
    logic ready;
    gjls_pkg::job_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gjls_res_if;
    logic valid;
    logic ready;
    gjls_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gjls_cfg_if;
    logic valid;
    logic ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/gjls_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjls_ram
// Generic single port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gjls_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write or read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[hdl/gang_job_list_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gang_job_list_scheduler
// Greedy gang scheduler: a job takes the next window of table entries, the
// table being stably sorted by finish time when the window runs out.
// ----------------------------------------------------------------------------
// After reset a clearing pass loads all 64 entries with ids and zero finish times.
// A job gives one result beat per gang member, one table access a cycle; a
// rejected job gives a single error beat.
// A sort of n entries is an insertion sort on the same port, run before the
// window is read. One job at a time: the next waits until the last beat leaves.
// Reset is asynchronous, active low; the count register resets to 64.
module gang_job_list_scheduler (
    input  wire logic clk,
    input  wire logic rst_n,
    gjls_job_if.sink   job,
    gjls_res_if.source res,
    gjls_cfg_if.sink   cfg
);
    import gjls_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_ERR   = 13'b0000000000100,
        S_LRD   = 13'b0000000001000,
        S_LCHK  = 13'b0000000010000,
        S_SRD   = 13'b0000000100000,
        S_SCMP  = 13'b0000001000000,
        S_SINS  = 13'b0000010000000,
        S_WRD   = 13'b0000100000000,
        S_WOUT  = 13'b0001000000000,
        S_EMIT  = 13'b0010000000000,
        S_SKEY  = 13'b0100000000000,
        S_SNXT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] count_reg;
    logic [CntBits-1:0] wend_reg, wend_next;
    logic [CntBits-1:0] i_reg, i_next, j_reg, j_next;
    logic [CntBits-1:0] first_reg, first_next, need_reg, need_next;
    entry_t key_reg, key_next;
    logic [TimeBits-1:0] ready_reg, ready_next, proc_reg, proc_next;
    logic [TimeBits-1:0] start_reg, start_next, fin_reg, fin_next;
    result_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic we;
    logic [IdxBits-1:0] addr;
    entry_t wdata, rdata;
    logic [CntBits-1:0] cnt_use;
    logic [CntBits-1:0] jm1;
    logic [TimeBits:0] sum;
    logic [CntBits:0] wsum;

    gjls_ram #(.Width(EntryBits), .Depth(MaxProcs)) u_tab (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // count clamp to 1..64
    always_comb
    begin
        priority if (count_reg == 7'd0)
            cnt_use = CntBits'(1);
        else if (count_reg > 7'(MaxProcs))
            cnt_use = CntBits'(MaxProcs);
        else
            cnt_use = CntBits'(count_reg);
    end

    assign sum = {1'b0, start_reg} + {1'b0, proc_reg};
    assign wsum = {1'b0, wend_reg} + {1'b0, need_reg};
    assign jm1 = j_reg - 1'b1;

    assign job.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign res.valid = out_valid_reg;
    assign res.data = out_reg;

    // control and table sequencing
    always_comb
    begin
        state_next = state_reg;
        wend_next = wend_reg;
        i_next = i_reg;
        j_next = j_reg;
        first_next = first_reg;
        need_next = need_reg;
        key_next = key_reg;
        ready_next = ready_reg;
        proc_next = proc_reg;
        start_next = start_reg;
        fin_next = fin_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        we = 1'b0;
        addr = i_reg[IdxBits-1:0];
        wdata = key_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wdata.id = i_reg[IdxBits-1:0];
                wdata.fin = '0;
                i_next = i_reg + 1'b1;
                if (i_reg == CntBits'(MaxProcs - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (job.valid && job.ready)
                begin
                    ready_next = job.data.arrive_time;
                    proc_next = job.data.run_time;
                    need_next = CntBits'(job.data.gang_size);
                    if (job.data.gang_size == 7'd0 ||
                        job.data.gang_size > 7'(cnt_use))
                        state_next = S_ERR;
                    else
                        state_next = S_LRD;
                end
            end
            S_ERR:
            begin
                out_next = '0;
                out_next.last = 1'b1;
                out_next.error = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_LRD:
            begin
                // pick window, sort if it overflows
                if (wend_reg > cnt_use || wsum > {1'b0, cnt_use})
                begin
                    first_next = '0;
                    i_next = CntBits'(1);
                    state_next = S_SRD;
                end
                else
                begin
                    first_next = wend_reg;
                    i_next = wsum[CntBits-1:0] - 1'b1;
                    state_next = S_LCHK;
                end
            end
            S_SRD:
            begin
                // read entry i, or finish the sort
                if (i_reg >= cnt_use)
                begin
                    i_next = need_reg - 1'b1;
                    state_next = S_LCHK;
                end
                else
                begin
                    j_next = i_reg;
                    state_next = S_SKEY;
                end
            end
            S_SKEY:
            begin
                // key = entry i, read entry j-1
                key_next = rdata;
                addr = jm1[IdxBits-1:0];
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                // shift entry j-1 up while it finishes later than the key
                if (rdata.fin > key_reg.fin)
                begin
                    we = 1'b1;
                    addr = j_reg[IdxBits-1:0];
                    wdata = rdata;
                    j_next = jm1;
                    state_next = (jm1 == CntBits'(0)) ? S_SINS : S_SNXT;
                end
                else
                    state_next = S_SINS;
            end
            S_SNXT:
            begin
                addr = jm1[IdxBits-1:0];
                state_next = S_SCMP;
            end
            S_SINS:
            begin
                we = 1'b1;
                addr = j_reg[IdxBits-1:0];
                wdata = key_reg;
                i_next = i_reg + 1'b1;
                state_next = S_SRD;
            end
            S_LCHK:
            begin
                // read issued for last window entry
                start_next = ready_reg;
                state_next = S_WRD;
                i_next = i_reg;
                j_next = '0;
            end
            S_WRD:
            begin
                if (j_reg == '0)
                begin
                    if (rdata.fin > ready_reg)
                        start_next = rdata.fin;
                    j_next = CntBits'(1);
                    i_next = first_reg;
                    wend_next = first_reg + need_reg;
                end
                else
                begin
                    fin_next = sum[TimeBits] ? '1 : sum[TimeBits-1:0];
                    state_next = S_WOUT;
                end
            end
            S_WOUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    we = 1'b1;
                    wdata.id = rdata.id;
                    wdata.fin = fin_reg;
                    out_next.cpu_id = 6'(rdata.id);
                    out_next.start_time = start_reg;
                    out_next.done_time = fin_reg;
                    out_next.last = (i_reg + 1'b1 == wend_reg);
                    out_next.error = 1'b0;
                    out_valid_next = 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == wend_reg) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                state_next = S_WOUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= 7'd64;
            wend_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                count_reg <= cfg.data;
            wend_reg <= wend_next;
            i_reg <= i_next;
            j_reg <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        need_reg <= need_next;
        key_reg <= key_next;
        ready_reg <= ready_next;
        proc_reg <= proc_next;
        start_reg <= start_next;
        fin_reg <= fin_next;
        out_reg <= out_next;
    end
endmodule
`default_nettype wire

[test/gjls_checker.sv]
// ----------------------------------------------------------------------------
// gjls_checker
// Watches the job, result and configuration channels of the gang job list
// scheduler, predicts the processor assignments of every accepted job and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gjls_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    input  wire logic        job_ready,
    input  gjls_pkg::job_t    job_data,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  gjls_pkg::result_t res_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [6:0]  cfg_data,
    output int               fail_count,
    output int               pending,
    output int               beats_seen,
    output int               error_beats,
    output int               sorts_done
);
    import gjls_pkg::*;

    // predicted scheduler state
    logic [IdxBits-1:0]  tbl_id  [MaxProcs];
    logic [TimeBits-1:0] tbl_fin [MaxProcs];
    logic [6:0]          win_end;
    logic [6:0]          proc_count;
    result_t             sched_q[$];

    // table entries in use, clamped to 1..MaxProcs
    function automatic int active_count();
        int c;
        c = proc_count;
        if (c < 1) c = 1;
        if (c > MaxProcs) c = MaxProcs;
        return c;
    endfunction

    // stable insertion sort of the first n entries by finish time
    task automatic sort_by_finish(input int n);
        logic [TimeBits-1:0] f;
        logic [IdxBits-1:0]  id;
        int j;
        for (int i = 1; i < n; i++)
        begin
            f = tbl_fin[i];
            id = tbl_id[i];
            j = i;
            while (j > 0 && tbl_fin[j-1] > f)
            begin
                tbl_fin[j] = tbl_fin[j-1];
                tbl_id[j] = tbl_id[j-1];
                j--;
            end
            tbl_fin[j] = f;
            tbl_id[j] = id;
        end
        sorts_done++;
    endtask

    // place one job and queue the beats it should produce
    task automatic schedule_job(input job_t jb);
        int need, cnt, first;
        logic [TimeBits-1:0] start;
        logic [TimeBits:0]   fin;
        result_t r;
        need = jb.gang_size;
        cnt = active_count();
        if (need == 0 || need > cnt)
        begin
            r = '0;
            r.last = 1'b1;
            r.error = 1'b1;
            sched_q.push_back(r);
            return;
        end
        first = win_end;
        if (first + need > cnt)
        begin
            sort_by_finish(cnt);
            first = 0;
        end
        win_end = 7'(first + need);
        start = tbl_fin[first+need-1];
        if (start < jb.arrive_time) start = jb.arrive_time;
        fin = {1'b0, start} + {1'b0, jb.run_time};
        if (fin[TimeBits]) fin = {1'b0, {TimeBits{1'b1}}};
        for (int i = 0; i < need; i++)
        begin
            tbl_fin[first+i] = fin[TimeBits-1:0];
            r.cpu_id = tbl_id[first+i];
            r.start_time = start;
            r.done_time = fin[TimeBits-1:0];
            r.last = (i == need - 1);
            r.error = 1'b0;
            sched_q.push_back(r);
        end
    endtask

    // watch the channels
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < MaxProcs; i++)
            begin
                tbl_id[i] = IdxBits'(i);
                tbl_fin[i] = '0;
            end
            win_end = '0;
            proc_count = 7'd64;
            sched_q.delete();
            fail_count = 0;
            beats_seen = 0;
            error_beats = 0;
            sorts_done = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                beats_seen++;
                if (res_data.error) error_beats++;
                if (sched_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %p", res_data);
                end
                else
                begin
                    e = sched_q.pop_front();
                    if (e !== res_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", e, res_data);
                    end
                end
            end
            if (cfg_valid && cfg_ready) proc_count = cfg_data;
            if (job_valid && job_ready) schedule_job(job_data);
        end
        pending = sched_q.size();
    end
endmodule

[test/tb_gang_job_list_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_gang_job_list_scheduler
// Drives jobs and processor count writes into the gang job list scheduler
// under random idling on both channels; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_gang_job_list_scheduler;
    import gjls_pkg::*;

    logic clk;
    logic rst_n;
    int   cycle_cnt = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count, pending, beats_seen, error_beats, sorts_done;
    int   jobs_sent;

    gjls_job_if job ();
    gjls_res_if res ();
    gjls_cfg_if cfg ();

    gang_job_list_scheduler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    gjls_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job.valid),
        .job_ready   (job.ready),
        .job_data    (job.data),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .res_data    (res.data),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_data    (cfg.data),
        .fail_count  (fail_count),
        .pending     (pending),
        .beats_seen  (beats_seen),
        .error_beats (error_beats),
        .sorts_done  (sorts_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit: the run fails on timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 20000000)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    // result sink with random stalls
    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= recv_idle_pct);

    // send one job beat, idling at random first
    task automatic send_job(input job_t jb);
        if ($urandom_range(99) < send_idle_pct)
        begin
            job.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        job.valid <= 1'b1;
        job.data <= jb;
        @(posedge clk);
        while (!job.ready) @(posedge clk);
        jobs_sent++;
    endtask

    task automatic send_fields(input logic [31:0] rt, input logic [31:0] pt,
                               input logic [6:0] nd);
        job_t jb;
        jb.arrive_time = rt;
        jb.run_time = pt;
        jb.gang_size = nd;
        send_job(jb);
    endtask

    // stop sending and wait until every expected beat has arrived
    task automatic drain();
        job.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // write the processor count once every expected beat has arrived
    task automatic write_count(input logic [6:0] v);
        drain();
        repeat (200) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // random time with a bias toward small values and the top end
    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0: return $urandom_range(255);
            1: return 32'hFFFF_FFFF - $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_jobs(input int n, input int cnt);
        int nd;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: nd = $urandom_range(127);
                1: nd = 0;
                default: nd = $urandom_range(cnt < 8 ? cnt : 8, 1);
            endcase
            send_fields(rand_time(), rand_time(), 7'(nd));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        jobs_sent = 0;
        job.valid = 1'b0;
        job.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        send_idle_pct = 31;
        recv_idle_pct = 74;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, errors, saturation, wrap with sort
        send_fields(32'd0, 32'd0, 7'd1);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1);
        send_fields(32'd5, 32'd10, 7'd0);
        send_fields(32'd5, 32'd10, 7'd65);
        send_fields(32'd5, 32'd10, 7'd127);
        send_fields(32'd100, 32'd7, 7'd62);
        send_fields(32'd3, 32'd1, 7'd2);
        send_fields(32'd0, 32'd9, 7'd64);
        send_fields(32'hAAAA_AAAA, 32'h5555_5555, 7'd33);
        send_fields(32'h5555_5555, 32'hAAAA_AAAA, 7'd31);
        write_count(7'd1);
        send_fields(32'd1, 32'd1, 7'd1);
        send_fields(32'd1, 32'd1, 7'd2);
        write_count(7'd0);
        send_fields(32'd2, 32'd2, 7'd1);
        write_count(7'd127);
        send_fields(32'd2, 32'd2, 7'd64);
        send_fields(32'd2, 32'd2, 7'd65);
        write_count(7'd64);
        send_fields(32'd2, 32'd2, 7'd64);

        // random phases across count settings and idling modes
        random_jobs(110, 64);
        write_count(7'd5);
        random_jobs(110, 5);
        send_idle_pct = 74;
        recv_idle_pct = 31;
        write_count(7'd17);
        random_jobs(110, 17);
        write_count(7'd2);
        random_jobs(60, 2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_count(7'd64);
        random_jobs(110, 64);

        drain();
        repeat (200) @(posedge clk);
        $display("%0d jobs sent, %0d result beats checked (%0d error beats)",
                 jobs_sent, beats_seen, error_beats);
        $display("%0d table sorts predicted over counts 0..127 written", sorts_done);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
